// ----- rtl/ili_pkg.sv -----
// Shared types and codes for the indexed list block.
package ili_pkg;

  // Widths of the item fields.
  localparam int ACTION_W = 3;
  localparam int INDEX_W  = 7;
  localparam int DATA_W   = 32;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 2;

  // Position bus to the cells, wide enough for a capacity of 1024.
  localparam int POS_W = 11;

  localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_APPEND = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_READ   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_WRITE  = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [INDEX_W-1:0]  index;
    logic [DATA_W-1:0]   write_data;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0]   read_data;
    logic [COUNT_W-1:0]  count;
    logic [STATUS_W-1:0] status;
  } rsp_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_WRITE,
    CELL_READ
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [POS_W-1:0] pos;
  } cell_ctrl_t;

endpackage

// ----- rtl/ili_cell.sv -----
// One element cell of the list chain.
module ili_cell #(
  parameter int IDX = 0,
  parameter int EW  = 32
) (
  input  logic                clk,
  input  ili_pkg::cell_ctrl_t ctrl,
  input  logic [EW-1:0]       wdata,
  input  logic [EW-1:0]       from_left,
  input  logic [EW-1:0]       from_right,
  output logic [EW-1:0]       data,
  output logic                hit
);
  import ili_pkg::*;

  localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

  // Insert moves every cell above the position one place up; remove pulls every cell
  // at or above the position one place down. Cells past the count hold don't-care data.
  always_ff @(posedge clk) begin
    case (ctrl.op)
      CELL_INSERT: begin
        if (MY_POS > ctrl.pos) begin
          data <= from_left;
        end else if (MY_POS == ctrl.pos) begin
          data <= wdata;
        end
      end
      CELL_REMOVE: begin
        if (MY_POS >= ctrl.pos) begin
          data <= from_right;
        end
      end
      CELL_WRITE: begin
        if (MY_POS == ctrl.pos) begin
          data <= wdata;
        end
      end
      default: begin
      end
    endcase
  end

  assign hit = (ctrl.op == CELL_READ) && (MY_POS == ctrl.pos);

endmodule

// ----- rtl/ili_rdtree.sv -----
// Registered OR tree that gathers the selected cell's data for a read.
module ili_rdtree #(
  parameter int N  = 64,
  parameter int EW = 32
) (
  input  logic                 clk,
  input  logic [N-1:0][EW-1:0] leaf_data,
  input  logic [N-1:0]         leaf_hit,
  output logic [EW-1:0]        root
);
  import ili_pkg::*;

  localparam int LVL = $clog2(N);
  localparam int NL  = 1 << LVL;

  logic [EW-1:0] node [1:2*NL-1];

  for (genvar i = 0; i < NL; i++) begin : g_leaf
    if (i < N) begin : g_real
      always_ff @(posedge clk) begin
        node[NL+i] <= leaf_hit[i] ? leaf_data[i] : '0;
      end
    end else begin : g_pad
      always_ff @(posedge clk) begin
        node[NL+i] <= '0;
      end
    end
  end

  for (genvar k = 1; k < NL; k++) begin : g_node
    always_ff @(posedge clk) begin
      node[k] <= node[2*k] | node[2*k+1];
    end
  end

  assign root = node[1];

endmodule

// ----- rtl/indexed_list_insert_remove.sv -----
// Top level of the indexed list: command decode, element count and result register.
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------------------------
//   command  | start / busy       | req  (action, index, write_data)
//   result   | done (one cycle)   | rsp  (read_data, count, status)
//
// An item is taken when start is high and busy is low; the cell chain applies any
// insert, remove or write on that same edge. The result is registered once the item
// has passed through the registered OR tree of the read path, and busy drops in the
// cycle the result is shown, so a new item can follow then.
// Reset clears the element count and control; cell contents are not cleared.
// The receiver cannot stall: done is high for exactly one cycle per item.
module indexed_list_insert_remove #(
  parameter int CAPACITY   = 64,
  parameter int ELEM_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  ili_pkg::req_t req,
  output logic          done,
  output ili_pkg::rsp_t rsp
);
  import ili_pkg::*;

  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int LVL = $clog2(CAPACITY);
  localparam int WW  = $clog2(LVL + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic              pending;
  logic [WW-1:0]     wait_cnt;
  logic [CW-1:0]     cnt_q;
  logic [CW-1:0]     cnt_next;
  logic [STATUS_W-1:0] st_q;
  logic [STATUS_W-1:0] st_next;
  logic              rd_q;
  logic              rd_next;
  logic              accept;
  cell_op_t          op_next;
  logic [POS_W-1:0]  pos_next;
  logic [POS_W-1:0]  idx_ext;
  logic [POS_W-1:0]  cnt_ext;
  cell_ctrl_t        ctrl;
  logic [ELEM_WIDTH-1:0] wdata;
  logic [CAPACITY-1:0][ELEM_WIDTH-1:0] cell_data;
  logic [CAPACITY-1:0] cell_hit;
  logic [ELEM_WIDTH-1:0] root;

  assign accept  = start && !pending;
  assign busy    = pending;
  assign idx_ext = POS_W'(req.index);
  assign cnt_ext = POS_W'(cnt_q);
  assign wdata   = ELEM_WIDTH'(req.write_data);

  always_comb begin
    op_next  = CELL_HOLD;
    pos_next = idx_ext;
    st_next  = ST_OK;
    cnt_next = cnt_q;
    rd_next  = 1'b0;
    unique case (req.action)
      ACT_INSERT: begin
        if (idx_ext > cnt_ext) begin
          st_next = ST_RANGE;
        end else if (cnt_q == CAP_C) begin
          st_next = ST_FULL;
        end else begin
          op_next  = CELL_INSERT;
          cnt_next = CW'(cnt_q + 1'b1);
        end
      end
      ACT_APPEND: begin
        pos_next = cnt_ext;
        if (cnt_q == CAP_C) begin
          st_next = ST_FULL;
        end else begin
          op_next  = CELL_INSERT;
          cnt_next = CW'(cnt_q + 1'b1);
        end
      end
      ACT_REMOVE: begin
        if (cnt_q == '0) begin
          st_next = ST_EMPTY;
        end else if (idx_ext >= cnt_ext) begin
          st_next = ST_RANGE;
        end else begin
          op_next  = CELL_REMOVE;
          cnt_next = CW'(cnt_q - 1'b1);
        end
      end
      ACT_READ: begin
        if (idx_ext >= cnt_ext) begin
          st_next = ST_RANGE;
        end else begin
          op_next = CELL_READ;
          rd_next = 1'b1;
        end
      end
      ACT_WRITE: begin
        if (idx_ext >= cnt_ext) begin
          st_next = ST_RANGE;
        end else begin
          op_next = CELL_WRITE;
        end
      end
      ACT_CLEAR: begin
        cnt_next = '0;
      end
      default: begin
      end
    endcase
  end

  assign ctrl.op  = accept ? op_next : CELL_HOLD;
  assign ctrl.pos = pos_next;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ELEM_WIDTH-1:0] left_d;
    logic [ELEM_WIDTH-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
    end
    ili_cell #(
      .IDX(i),
      .EW (ELEM_WIDTH)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .wdata     (wdata),
      .from_left (left_d),
      .from_right(right_d),
      .data      (cell_data[i]),
      .hit       (cell_hit[i])
    );
  end

  ili_rdtree #(
    .N (CAPACITY),
    .EW(ELEM_WIDTH)
  ) u_rdtree (
    .clk      (clk),
    .leaf_data(cell_data),
    .leaf_hit (cell_hit),
    .root     (root)
  );

  // Control and count.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending  <= 1'b0;
      wait_cnt <= '0;
      cnt_q    <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      if (accept) begin
        pending  <= 1'b1;
        wait_cnt <= WW'(LVL);
        cnt_q    <= cnt_next;
      end else if (pending) begin
        if (wait_cnt == '0) begin
          pending <= 1'b0;
          done    <= 1'b1;
        end else begin
          wait_cnt <= WW'(wait_cnt - 1'b1);
        end
      end
    end
  end

  // Result payload, loaded once the read tree has settled.
  always_ff @(posedge clk) begin
    if (accept) begin
      st_q <= st_next;
      rd_q <= rd_next;
    end
    if (pending && (wait_cnt == '0)) begin
      rsp.read_data <= rd_q ? DATA_W'(root) : '0;
      rsp.count     <= COUNT_W'(cnt_q);
      rsp.status    <= st_q;
    end
  end

  a_done_frees: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while the block is still busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_count_cap: assert property (@(posedge clk) disable iff (rst) cnt_q <= CAP_C)
    else $error("element count exceeds capacity");

  a_err_no_data: assert property (@(posedge clk) disable iff (rst)
    (done && (rsp.status != ST_OK)) |-> (rsp.read_data == '0))
    else $error("failed action returned nonzero read data");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (done && (rsp.status == ST_FULL)) |-> (cnt_q == CAP_C))
    else $error("full status reported with room in the list");

endmodule
